[src/bcmr_pkg.sv]
// Package with shared types and constants for the channel map remap table.
package bcmr_pkg;

  localparam int CH_W       = 6;
  localparam int MAP_BITS   = 37;
  localparam int MAP_EXT_W  = 2 ** CH_W;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_PAD_W  = OUT_DATA_W - 3 * CH_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SEL_SELF,
    SEL_TABLE,
    SEL_WRAP
  } sel_t;

  typedef struct packed {
    logic [CH_W-1:0] used_cnt;
    logic [CH_W-1:0] fill_ptr;
  } scan_res_t;

endpackage

[src/bcmr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module bcmr_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 37
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/bcmr_scan.sv]
// Upward scan of the channel map that fills the used list, pending queue and table.
module bcmr_scan #(
  parameter int NUM_CHANNELS = 37
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [bcmr_pkg::MAP_BITS-1:0]   map,
  output logic                            done,
  output bcmr_pkg::scan_res_t             res,
  output logic                            pend_we,
  output logic [$clog2(NUM_CHANNELS)-1:0] pend_waddr,
  output logic [bcmr_pkg::CH_W-1:0]       pend_wdata,
  output logic                            pend_re,
  output logic [$clog2(NUM_CHANNELS)-1:0] pend_raddr,
  input  logic [bcmr_pkg::CH_W-1:0]       pend_rdata,
  output logic                            used_we,
  output logic [$clog2(NUM_CHANNELS)-1:0] used_waddr,
  output logic [bcmr_pkg::CH_W-1:0]       used_wdata,
  output logic                            remap_we,
  output logic [$clog2(NUM_CHANNELS)-1:0] remap_waddr,
  output logic [bcmr_pkg::CH_W-1:0]       remap_wdata
);

  localparam int CW = bcmr_pkg::CH_W;
  localparam int AW = $clog2(NUM_CHANNELS);

  logic                               active;
  logic [CW-1:0]                      ch;
  logic [CW-1:0]                      cnt;
  logic [CW-1:0]                      rd;
  logic [CW-1:0]                      wr;
  logic                               fill_v;
  logic [CW-1:0]                      fill_ch;
  logic [bcmr_pkg::MAP_EXT_W-1:0]     map_ext;
  logic                               bit_set;
  logic                               last_ch;

  assign map_ext = {{(bcmr_pkg::MAP_EXT_W - bcmr_pkg::MAP_BITS){1'b0}}, map};
  assign bit_set = map_ext[ch];
  assign last_ch = (ch == CW'(NUM_CHANNELS - 1));
  assign done    = active && last_ch;

  assign pend_we    = active && !bit_set;
  assign pend_waddr = wr[AW-1:0];
  assign pend_wdata = ch;
  assign pend_re    = active && bit_set && (rd != wr);
  assign pend_raddr = rd[AW-1:0];

  assign used_we    = active && bit_set;
  assign used_waddr = cnt[AW-1:0];
  assign used_wdata = ch;

  assign remap_we    = fill_v;
  assign remap_waddr = pend_rdata[AW-1:0];
  assign remap_wdata = fill_ch;

  assign res.used_cnt = cnt;
  assign res.fill_ptr = rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      fill_v <= 1'b0;
      ch     <= '0;
      cnt    <= '0;
      rd     <= '0;
      wr     <= '0;
    end else begin
      fill_v <= pend_re;
      if (start) begin
        active <= 1'b1;
        ch     <= '0;
        cnt    <= '0;
        rd     <= '0;
        wr     <= '0;
      end else if (active) begin
        ch  <= ch + CW'(1);
        cnt <= cnt + CW'(bit_set);
        wr  <= wr + CW'(!bit_set);
        rd  <= rd + CW'(pend_re);
        if (last_ch) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    fill_ch <= ch;
  end

endmodule

[src/bcmr_emit.sv]
// Output pass that reads the table and used list and streams one word per channel.
module bcmr_emit #(
  parameter int NUM_CHANNELS = 37
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [bcmr_pkg::MAP_BITS-1:0]      map,
  input  bcmr_pkg::scan_res_t                res,
  output logic                               rd_en,
  output logic [$clog2(NUM_CHANNELS)-1:0]    remap_raddr,
  input  logic [bcmr_pkg::CH_W-1:0]          remap_rdata,
  output logic [$clog2(NUM_CHANNELS)-1:0]    used_raddr,
  input  logic [bcmr_pkg::CH_W-1:0]          used_rdata,
  output logic                               done,
  output logic                               busy,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [bcmr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic [0:0]                         m_axis_tuser,
  output logic                               m_axis_tlast
);

  localparam int CW = bcmr_pkg::CH_W;
  localparam int AW = $clog2(NUM_CHANNELS);

  logic                           active;
  logic [CW-1:0]                  k;
  logic [CW-1:0]                  m;
  logic [CW-1:0]                  uidx;
  logic                           p1_valid;
  logic [CW-1:0]                  p1_k;
  bcmr_pkg::sel_t                 p1_sel;
  logic                           p1_last;
  logic                           out_valid;
  logic [CW-1:0]                  out_k;
  logic [CW-1:0]                  out_mapped;
  logic [CW-1:0]                  out_cnt;
  logic                           out_err;
  logic                           out_last;
  logic [bcmr_pkg::MAP_EXT_W-1:0] map_ext;
  logic                           bit_set;
  logic                           last_k;
  logic                           load;
  logic                           issue;
  logic                           no_used;
  bcmr_pkg::sel_t                 sel;
  logic [CW-1:0]                  mapped;
  logic [CW-1:0]                  m_inc;

  assign map_ext = {{(bcmr_pkg::MAP_EXT_W - bcmr_pkg::MAP_BITS){1'b0}}, map};
  assign bit_set = map_ext[k];
  assign last_k  = (k == CW'(NUM_CHANNELS - 1));
  assign no_used = (res.used_cnt == '0);
  assign m_inc   = m + CW'(1);

  assign load  = p1_valid && (!out_valid || m_axis_tready);
  assign issue = active && (!p1_valid || load);
  assign done  = issue && last_k;
  assign busy  = p1_valid;

  assign rd_en       = issue;
  assign remap_raddr = k[AW-1:0];
  assign used_raddr  = m[AW-1:0];

  always_comb begin
    if (bit_set) begin
      sel = bcmr_pkg::SEL_SELF;
    end else if (uidx < res.fill_ptr) begin
      sel = bcmr_pkg::SEL_TABLE;
    end else begin
      sel = bcmr_pkg::SEL_WRAP;
    end
  end

  always_comb begin
    case (p1_sel)
      bcmr_pkg::SEL_SELF:  mapped = p1_k;
      bcmr_pkg::SEL_TABLE: mapped = remap_rdata;
      bcmr_pkg::SEL_WRAP:  mapped = no_used ? '0 : used_rdata;
      default:             mapped = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      p1_valid  <= 1'b0;
      out_valid <= 1'b0;
      k         <= '0;
      m         <= '0;
      uidx      <= '0;
    end else begin
      if (start) begin
        active <= 1'b1;
        k      <= '0;
        m      <= '0;
        uidx   <= '0;
      end else if (issue) begin
        k    <= k + CW'(1);
        uidx <= uidx + CW'(!bit_set);
        m    <= (m_inc == res.used_cnt) ? '0 : m_inc;
        if (last_k) begin
          active <= 1'b0;
        end
      end
      if (issue) begin
        p1_valid <= 1'b1;
      end else if (load) begin
        p1_valid <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p1_k    <= k;
      p1_sel  <= sel;
      p1_last <= last_k;
    end
    if (load) begin
      out_k      <= p1_k;
      out_mapped <= mapped;
      out_cnt    <= res.used_cnt;
      out_err    <= no_used;
      out_last   <= p1_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{bcmr_pkg::OUT_PAD_W{1'b0}}, out_cnt, out_mapped, out_k};
  assign m_axis_tuser  = out_err;
  assign m_axis_tlast  = out_last;

endmodule

[src/ble_channel_map_remap_table.sv]
// Top level of the data channel map remap table builder.
//
// A channel map enters on the s_axis channel, one bit per data channel in the
// low bits of the word. The block answers with one m_axis word per channel, in
// ascending channel order, and marks the word for the highest channel with
// tlast. Each word carries the channel, the channel used in its place and the
// number of used channels; tuser flags a map with no used channel, in which
// case every mapped channel is zero.
// A map is taken only while the block is idle. The scan pass steps through the
// channels in ascending order on the pending-queue RAM, the finish state after
// it takes the final table write, and the output pass reads the table RAM one
// entry per cycle while the receiver does not stall. A stall holds the output
// register and the read pipeline behind it; the pass resumes when tready
// returns.
// Reset returns the sequencer to idle; the RAMs need no clearing since every
// entry whose value is used is written earlier in the same map.
module ble_channel_map_remap_table #(
  parameter int NUM_CHANNELS = 37
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Fields from bit 0: channel_map[36:0], zero fill.
  input  logic [bcmr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Fields from bit 0: channel_index[5:0], mapped_channel[5:0], used_count[5:0], zero fill.
  output logic [bcmr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // Fields from bit 0: no_used_error.
  output logic [0:0]                      m_axis_tuser,
  output logic                            m_axis_tlast
);

  localparam int CW = bcmr_pkg::CH_W;
  localparam int AW = $clog2(NUM_CHANNELS);

  bcmr_pkg::state_t             state;
  bcmr_pkg::state_t             state_next;
  logic [bcmr_pkg::MAP_BITS-1:0] map;
  logic                         accept;
  logic                         scan_done;
  logic                         emit_start;
  logic                         emit_done;
  logic                         emit_busy;
  bcmr_pkg::scan_res_t          res;

  logic          pend_we;
  logic [AW-1:0] pend_waddr;
  logic [CW-1:0] pend_wdata;
  logic          pend_re;
  logic [AW-1:0] pend_raddr;
  logic [CW-1:0] pend_rdata;
  logic          used_we;
  logic [AW-1:0] used_waddr;
  logic [CW-1:0] used_wdata;
  logic [AW-1:0] used_raddr;
  logic [CW-1:0] used_rdata;
  logic          remap_we;
  logic [AW-1:0] remap_waddr;
  logic [CW-1:0] remap_wdata;
  logic [AW-1:0] remap_raddr;
  logic [CW-1:0] remap_rdata;
  logic          rd_en;

  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bcmr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    emit_start    = 1'b0;
    case (state)
      bcmr_pkg::ST_IDLE: begin
        s_axis_tready = !emit_busy;
        if (s_axis_tvalid && !emit_busy) begin
          state_next = bcmr_pkg::ST_SCAN;
        end
      end
      bcmr_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = bcmr_pkg::ST_FINISH;
        end
      end
      bcmr_pkg::ST_FINISH: begin
        emit_start = 1'b1;
        state_next = bcmr_pkg::ST_EMIT;
      end
      bcmr_pkg::ST_EMIT: begin
        if (emit_done) begin
          state_next = bcmr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bcmr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      map <= s_axis_tdata[bcmr_pkg::MAP_BITS-1:0];
    end
  end

  bcmr_scan #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (accept),
    .map         (map),
    .done        (scan_done),
    .res         (res),
    .pend_we     (pend_we),
    .pend_waddr  (pend_waddr),
    .pend_wdata  (pend_wdata),
    .pend_re     (pend_re),
    .pend_raddr  (pend_raddr),
    .pend_rdata  (pend_rdata),
    .used_we     (used_we),
    .used_waddr  (used_waddr),
    .used_wdata  (used_wdata),
    .remap_we    (remap_we),
    .remap_waddr (remap_waddr),
    .remap_wdata (remap_wdata)
  );

  bcmr_ram #(
    .WIDTH(CW),
    .DEPTH(NUM_CHANNELS)
  ) u_pend_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (pend_waddr),
    .wdata (pend_wdata),
    .re    (pend_re),
    .raddr (pend_raddr),
    .rdata (pend_rdata)
  );

  bcmr_ram #(
    .WIDTH(CW),
    .DEPTH(NUM_CHANNELS)
  ) u_used_ram (
    .clk   (clk),
    .we    (used_we),
    .waddr (used_waddr),
    .wdata (used_wdata),
    .re    (rd_en),
    .raddr (used_raddr),
    .rdata (used_rdata)
  );

  bcmr_ram #(
    .WIDTH(CW),
    .DEPTH(NUM_CHANNELS)
  ) u_remap_ram (
    .clk   (clk),
    .we    (remap_we),
    .waddr (remap_waddr),
    .wdata (remap_wdata),
    .re    (rd_en),
    .raddr (remap_raddr),
    .rdata (remap_rdata)
  );

  bcmr_emit #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_emit (
    .clk           (clk),
    .rst           (rst),
    .start         (emit_start),
    .map           (map),
    .res           (res),
    .rd_en         (rd_en),
    .remap_raddr   (remap_raddr),
    .remap_rdata   (remap_rdata),
    .used_raddr    (used_raddr),
    .used_rdata    (used_rdata),
    .done          (emit_done),
    .busy          (emit_busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef SYNTH
  a_scan_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    scan_done |-> state == bcmr_pkg::ST_SCAN)
    else $error("scan finished outside the scan state");

  a_no_table_write_in_emit: assert property (@(posedge clk) disable iff (rst)
    remap_we |-> state != bcmr_pkg::ST_EMIT && state != bcmr_pkg::ST_IDLE)
    else $error("table written while it is being read out");

  a_reads_only_in_emit: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> state == bcmr_pkg::ST_EMIT)
    else $error("table read issued outside the output pass");
`endif

endmodule

[tb/sv/ble_channel_map_remap_table_tb.sv]
// Self-checking testbench for the data channel map remap table builder.
`timescale 1ns / 100ps

module ble_channel_map_remap_table_tb;

  localparam int CH_W       = bcmr_pkg::CH_W;
  localparam int MAP_BITS   = bcmr_pkg::MAP_BITS;
  localparam int IN_DATA_W  = bcmr_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = bcmr_pkg::OUT_DATA_W;
  localparam int NUM_CH = 37;
  localparam int LAST_CH = NUM_CH - 1;
  localparam longint RUN_LIMIT_NS = 5_000_000;

  typedef struct {
    logic [CH_W-1:0] index;
    logic [CH_W-1:0] mapped;
    logic [CH_W-1:0] used;
    logic            no_used;
    logic            last;
  } remap_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  remap_word_t pending_words[$];
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  ble_channel_map_remap_table #(
    .NUM_CHANNELS(NUM_CH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Builds the full remap table for one map and queues one word per channel.
  task automatic queue_remap_words(input logic [MAP_BITS-1:0] chmap);
    logic [CH_W-1:0] used_list[NUM_CH];
    logic [CH_W-1:0] unused_fifo[NUM_CH];
    logic [CH_W-1:0] remap[NUM_CH];
    int              n_used;
    int              rd;
    int              wr;
    int              u;
    remap_word_t     w;
    n_used = 0;
    rd = 0;
    wr = 0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (ch < MAP_BITS && chmap[ch]) begin
        remap[ch] = CH_W'(ch);
        used_list[n_used] = CH_W'(ch);
        n_used++;
        if (rd != wr) begin
          remap[unused_fifo[rd]] = CH_W'(ch);
          rd++;
        end
      end else begin
        unused_fifo[wr] = CH_W'(ch);
        wr++;
      end
    end
    // Channels left over wrap onto the used list, or go to zero if it is empty.
    while (rd < wr) begin
      u = int'(unused_fifo[rd]);
      remap[u] = (n_used != 0) ? used_list[u % n_used] : '0;
      rd++;
    end
    for (int k = 0; k < NUM_CH; k++) begin
      w.index = CH_W'(k);
      w.mapped = remap[k];
      w.used = CH_W'(n_used);
      w.no_used = (n_used == 0);
      w.last = (k == LAST_CH);
      pending_words.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    remap_word_t w;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        queue_remap_words(s_axis_tdata[MAP_BITS-1:0]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_words.size() == 0) begin
          report_mismatch("word with none pending", int'(m_axis_tdata[CH_W-1:0]), -1);
        end else begin
          w = pending_words.pop_front();
          if (m_axis_tdata[CH_W-1:0] !== w.index)
            report_mismatch("channel_index", int'(m_axis_tdata[CH_W-1:0]), int'(w.index));
          if (m_axis_tdata[2*CH_W-1:CH_W] !== w.mapped)
            report_mismatch("mapped_channel", int'(m_axis_tdata[2*CH_W-1:CH_W]),
                            int'(w.mapped));
          if (m_axis_tdata[3*CH_W-1:2*CH_W] !== w.used)
            report_mismatch("used_count", int'(m_axis_tdata[3*CH_W-1:2*CH_W]),
                            int'(w.used));
          if (m_axis_tuser[0] !== w.no_used)
            report_mismatch("no_used_error", int'(m_axis_tuser[0]), int'(w.no_used));
          if (m_axis_tlast !== w.last)
            report_mismatch("last_entry", int'(m_axis_tlast), int'(w.last));
        end
      end
    end
  end

  // Called at a rising edge; returns at the edge where the map is taken.
  task automatic send_map(input logic [MAP_BITS-1:0] chmap);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_DATA_W'(chmap);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  function automatic logic [MAP_BITS-1:0] random_map();
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(5))
      0: return a[MAP_BITS-1:0] & b[MAP_BITS-1:0] & c[MAP_BITS-1:0];
      1: return a[MAP_BITS-1:0] | b[MAP_BITS-1:0] | c[MAP_BITS-1:0];
      2: return MAP_BITS'(1) << $urandom_range(MAP_BITS - 1);
      3: return (MAP_BITS'(1) << $urandom_range(MAP_BITS - 1))
              | (MAP_BITS'(1) << $urandom_range(MAP_BITS - 1));
      4: return ~(MAP_BITS'(1) << $urandom_range(MAP_BITS - 1));
      default: return a[MAP_BITS-1:0];
    endcase
  endfunction

  task automatic test_directed();
    logic [MAP_BITS-1:0] maps[$];
    maps = '{'0, '1, MAP_BITS'(1), MAP_BITS'(1) << LAST_CH,
             (MAP_BITS'(1) << LAST_CH) | MAP_BITS'(1),
             ~(MAP_BITS'(1) << LAST_CH), ~MAP_BITS'(1),
             MAP_BITS'({MAP_BITS/2{2'b01}}), MAP_BITS'({MAP_BITS/2{2'b10}}),
             MAP_BITS'(37'h00_0007_FFFF), MAP_BITS'(37'h1F_FFF8_0000),
             MAP_BITS'(37'h00_0000_0003), MAP_BITS'(37'h18_0000_0000),
             MAP_BITS'(37'h00_0004_0000), MAP_BITS'(37'h11_1111_1111)};
    foreach (maps[i]) send_map(maps[i]);
  endtask

  task automatic test_random(input int n_maps, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (n_maps) send_map(random_map());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 6;
    recv_idle_pct = 72;
    test_directed();
    test_random(49, 6, 72);
    test_random(48, 72, 6);
    test_random(48, 0, 0);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
